// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, prop must hold at the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/lqm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager package
// Sizes, field types, operation and status codes, and the control structs
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lqm_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int NUM_ENTRIES = 64;

  localparam int MODE_W   = 2;
  localparam int QUEUE_W  = 3;
  localparam int ENTRY_W  = 6;
  localparam int STATUS_W = 2;

  localparam int LINK_W = $clog2(NUM_ENTRIES + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int EIDX_W = $clog2(NUM_ENTRIES);

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [QUEUE_W-1:0]  queue_t;
  typedef logic [ENTRY_W-1:0]  entry_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [LINK_W-1:0]   link_t;

  localparam link_t NIL = LINK_W'(NUM_ENTRIES);

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_POP    = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_EMPTY     = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic    load_req;
    logic    init_walk;
    logic    rd_en;
    logic    advance;
    logic    upd_a;
    logic    upd_b;
    logic    code_load;
    status_t code;
    logic    out_load;
  } lqm_cmd_t;

  typedef struct packed {
    logic    is_append;
    logic    is_pop;
    logic    reject;
    status_t reject_code;
    logic    hit;
    logic    nx_nil;
    logic    steps_max;
  } lqm_stat_t;

endpackage

// ===== rtl/core/lqm_ifs.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager channels
// Valid/ready interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface lqm_req_if;
  logic           valid;
  logic           ready;
  lqm_pkg::mode_t  mode;
  lqm_pkg::queue_t queue_id;
  lqm_pkg::entry_t entry_id;

  modport source (output valid, output mode, output queue_id, output entry_id, input ready);
  modport sink (input valid, input mode, input queue_id, input entry_id, output ready);
endinterface

interface lqm_rsp_if;
  logic             valid;
  logic             ready;
  lqm_pkg::entry_t  out_entry;
  lqm_pkg::status_t status;

  modport source (output valid, output out_entry, output status, input ready);
  modport sink (input valid, input out_entry, input status, output ready);
endinterface

// ===== rtl/core/lqm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/lqm_dpath.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager datapath
// Head and tail registers, the next-link RAM, the walk registers and the
// response registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module lqm_dpath (
  input  logic               clk,
  input  logic               rst,
  input  lqm_pkg::lqm_cmd_t  cmd,
  output lqm_pkg::lqm_stat_t stat,
  input  lqm_pkg::mode_t     in_mode,
  input  lqm_pkg::queue_t    in_queue,
  input  lqm_pkg::entry_t    in_entry,
  output lqm_pkg::entry_t    out_entry,
  output lqm_pkg::status_t   out_status
);

  lqm_pkg::mode_t   req_mode;
  lqm_pkg::queue_t  req_queue;
  lqm_pkg::entry_t  req_entry;
  lqm_pkg::link_t   head [lqm_pkg::NUM_QUEUES];
  lqm_pkg::link_t   tail [lqm_pkg::NUM_QUEUES];
  lqm_pkg::link_t   cur;
  lqm_pkg::link_t   prev;
  lqm_pkg::link_t   steps;
  lqm_pkg::status_t res_code;

  logic [lqm_pkg::QIDX_W-1:0] q_idx;
  lqm_pkg::link_t             e_link;
  lqm_pkg::link_t             head_q;
  lqm_pkg::link_t             tail_q;
  lqm_pkg::link_t             rd_data;
  logic                       q_bad;
  logic                       e_bad;
  logic                       is_append;
  logic                       is_pop;
  logic                       is_remove;
  logic                       head_we;
  lqm_pkg::link_t             head_wd;
  logic                       tail_we;
  lqm_pkg::link_t             tail_wd;
  logic                       wr_en;
  logic [lqm_pkg::EIDX_W-1:0] wr_addr;
  lqm_pkg::link_t             wr_data;

  assign q_idx     = lqm_pkg::QIDX_W'(req_queue);
  assign e_link    = lqm_pkg::LINK_W'(req_entry);
  assign head_q    = head[q_idx];
  assign tail_q    = tail[q_idx];
  assign q_bad     = 32'(req_queue) >= lqm_pkg::NUM_QUEUES;
  assign e_bad     = 32'(req_entry) >= lqm_pkg::NUM_ENTRIES;
  assign is_append = req_mode == lqm_pkg::MODE_APPEND;
  assign is_pop    = req_mode == lqm_pkg::MODE_POP;
  assign is_remove = req_mode == lqm_pkg::MODE_REMOVE;

  always_comb begin
    stat.is_append   = is_append;
    stat.is_pop      = is_pop;
    stat.reject      = 1'b1;
    stat.reject_code = lqm_pkg::STAT_DONE;
    if (is_append) begin
      stat.reject      = q_bad || e_bad;
      stat.reject_code = lqm_pkg::STAT_NOT_FOUND;
    end else if (is_pop) begin
      stat.reject      = q_bad || (head_q == lqm_pkg::NIL);
      stat.reject_code = lqm_pkg::STAT_EMPTY;
    end else if (is_remove) begin
      stat.reject      = q_bad || e_bad || (head_q == lqm_pkg::NIL);
      stat.reject_code = lqm_pkg::STAT_NOT_FOUND;
    end
    stat.hit       = is_pop || (cur == e_link);
    stat.nx_nil    = rd_data == lqm_pkg::NIL;
    stat.steps_max = steps >= lqm_pkg::LINK_W'(lqm_pkg::NUM_ENTRIES);
  end

  always_comb begin
    head_we = 1'b0;
    head_wd = rd_data;
    tail_we = 1'b0;
    tail_wd = lqm_pkg::NIL;
    wr_en   = 1'b0;
    wr_addr = tail_q[lqm_pkg::EIDX_W-1:0];
    wr_data = e_link;
    if (cmd.upd_a) begin
      if (is_append) begin
        wr_en   = tail_q != lqm_pkg::NIL;
        head_we = tail_q == lqm_pkg::NIL;
        head_wd = e_link;
        tail_we = 1'b1;
        tail_wd = e_link;
      end else if (is_pop) begin
        head_we = 1'b1;
        tail_we = rd_data == lqm_pkg::NIL;
      end else begin
        head_we = prev == lqm_pkg::NIL;
        wr_en   = prev != lqm_pkg::NIL;
        wr_addr = prev[lqm_pkg::EIDX_W-1:0];
        wr_data = rd_data;
        tail_we = cur == tail_q;
        tail_wd = prev;
      end
    end else if (cmd.upd_b) begin
      wr_en   = 1'b1;
      wr_addr = is_append ? req_entry[lqm_pkg::EIDX_W-1:0] : cur[lqm_pkg::EIDX_W-1:0];
      wr_data = lqm_pkg::NIL;
    end
  end

  lqm_ram #(
    .WIDTH (lqm_pkg::LINK_W),
    .DEPTH (lqm_pkg::NUM_ENTRIES)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cur[lqm_pkg::EIDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lqm_pkg::NUM_QUEUES; i++) begin
        head[i] <= lqm_pkg::NIL;
        tail[i] <= lqm_pkg::NIL;
      end
      steps <= '0;
    end else begin
      if (head_we) begin
        head[q_idx] <= head_wd;
      end
      if (tail_we) begin
        tail[q_idx] <= tail_wd;
      end
      if (cmd.init_walk) begin
        steps <= '0;
      end else if (cmd.advance) begin
        steps <= steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode  <= in_mode;
      req_queue <= in_queue;
      req_entry <= in_entry;
    end
    if (cmd.init_walk) begin
      cur  <= head_q;
      prev <= lqm_pkg::NIL;
    end else if (cmd.advance) begin
      cur  <= rd_data;
      prev <= cur;
    end
    if (cmd.code_load) begin
      res_code <= cmd.code;
    end
    if (cmd.out_load) begin
      out_status <= res_code;
      out_entry  <= (is_pop && res_code == lqm_pkg::STAT_DONE) ?
                    lqm_pkg::ENTRY_W'(cur) : '0;
    end
  end

endmodule

// ===== rtl/core/lqm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager controller
// Sequences one request at a time through decode, list walk, link updates
// and response, and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lqm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  lqm_pkg::lqm_stat_t stat,
  output lqm_pkg::lqm_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECIDE  = 7'b0000010,
    S_READ    = 7'b0000100,
    S_CHECK   = 7'b0001000,
    S_UPD_A   = 7'b0010000,
    S_UPD_B   = 7'b0100000,
    S_RESPOND = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = lqm_pkg::STAT_DONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.init_walk = 1'b1;
        if (stat.reject) begin
          cmd.code_load = 1'b1;
          cmd.code      = stat.reject_code;
          state_next    = S_RESPOND;
        end else if (stat.is_append) begin
          state_next = S_UPD_A;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.hit) begin
          state_next = S_UPD_A;
        end else if (stat.nx_nil || stat.steps_max) begin
          cmd.code_load = 1'b1;
          cmd.code      = lqm_pkg::STAT_NOT_FOUND;
          state_next    = S_RESPOND;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_UPD_A: begin
        cmd.upd_a  = 1'b1;
        state_next = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.upd_b     = 1'b1;
        cmd.code_load = 1'b1;
        cmd.code      = lqm_pkg::STAT_DONE;
        state_next    = S_RESPOND;
      end
      S_RESPOND: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_accept_decide, req_valid && req_ready, state == S_DECIDE, "Accepted request did not reach decode.")
  `ASSERT_NEXT(a_load_valid, cmd.out_load, rsp_valid, "Loaded response is not presented.")
  `ASSERT_ALWAYS(a_check_after_read, (state == S_CHECK) |-> ($past(state) == S_READ), "Link check without a preceding read.")

endmodule

// ===== rtl/core/linked_queue_manager.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager
// Several FIFO queues threaded through one table of entries by next links.
// ----------------------------------------------------------------------------
// Requests arrive on req (mode, queue_id, entry_id) and each gives exactly one
// response transaction on rsp (out_entry, status). Both channels use valid and
// ready; a transaction completes when both are high at a rising clock edge.
// One request is processed at a time. A rejected or unused request goes from
// decode straight to the response, an append updates the links directly, a
// pop reads the next link of the head first, and a remove walks the list
// from the head past at most NUM_ENTRIES entries. Each walk step is one read
// of the next-link RAM, whose single read port has registered data. The
// response is presented in an output register in the same cycle that the
// block is ready again, so a new request is taken while an earlier response
// still waits. If the receiver stalls, the block finishes its next request
// and then holds it until rsp is free.
// Synchronous reset empties all queues; the next-link table needs no clearing.
// ----------------------------------------------------------------------------
module linked_queue_manager (
  input logic      clk,
  input logic      rst,
  lqm_req_if.sink  req,
  lqm_rsp_if.source rsp
);

  lqm_pkg::lqm_cmd_t  cmd;
  lqm_pkg::lqm_stat_t stat;

  lqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lqm_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (req.mode),
    .in_queue   (req.queue_id),
    .in_entry   (req.entry_id),
    .out_entry  (rsp.out_entry),
    .out_status (rsp.status)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager testbench
// Drives requests into the queue manager with random idle cycles on both
// channels, predicts every response from a shadow copy of the head, tail and
// next-link tables, and compares each response field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lqm_pkg::*;

typedef struct packed {
  entry_t  out_entry;
  status_t status;
} rsp_fields_t;

class queue_table_scoreboard;
  link_t       head_q[NUM_QUEUES];
  link_t       tail_q[NUM_QUEUES];
  link_t       next_e[NUM_ENTRIES];
  rsp_fields_t expected_rsp[$];
  int unsigned mismatches;

  function new();
    foreach (head_q[i]) begin
      head_q[i] = NIL;
      tail_q[i] = NIL;
    end
    foreach (next_e[i]) next_e[i] = '0;
    mismatches = 0;
  endfunction

  function link_t after(link_t e);
    return (e < NIL) ? next_e[e[EIDX_W-1:0]] : NIL;
  endfunction

  function void relink(link_t e, link_t v);
    if (e < NIL) next_e[e[EIDX_W-1:0]] = v;
  endfunction

  function void collect(input queue_t qid, output entry_t members[$]);
    link_t cur;
    int    n;
    members = {};
    cur = head_q[qid];
    n = 0;
    while (cur != NIL && n <= NUM_ENTRIES) begin
      members.push_back(cur[ENTRY_W-1:0]);
      cur = after(cur);
      n++;
    end
  endfunction

  function void occupancy(output bit held[NUM_ENTRIES]);
    entry_t members[$];
    foreach (held[i]) held[i] = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      collect(queue_t'(q), members);
      foreach (members[i]) held[members[i]] = 1'b1;
    end
  endfunction

  function void note_request(mode_t mode, queue_t qid, entry_t eid);
    link_t       prev;
    link_t       cur;
    link_t       nx;
    int unsigned steps;
    bit          found;
    rsp_fields_t r;
    r.out_entry = '0;
    r.status = STAT_DONE;
    case (mode)
      MODE_APPEND: begin
        if (tail_q[qid] == NIL) begin
          head_q[qid] = link_t'(eid);
        end else begin
          relink(tail_q[qid], link_t'(eid));
        end
        tail_q[qid] = link_t'(eid);
        next_e[eid] = NIL;
      end
      MODE_POP: begin
        if (head_q[qid] == NIL) begin
          r.status = STAT_EMPTY;
        end else begin
          cur = head_q[qid];
          nx = after(cur);
          r.out_entry = cur[ENTRY_W-1:0];
          head_q[qid] = nx;
          if (nx == NIL) tail_q[qid] = NIL;
          relink(cur, NIL);
        end
      end
      MODE_REMOVE: begin
        if (head_q[qid] == NIL) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          prev = NIL;
          cur = head_q[qid];
          steps = 0;
          found = 1'b0;
          forever begin
            if (cur == link_t'(eid)) begin
              found = 1'b1;
              break;
            end
            if (after(cur) == NIL || steps >= NUM_ENTRIES) break;
            prev = cur;
            cur = after(cur);
            steps++;
          end
          if (found) begin
            nx = after(cur);
            if (prev == NIL) begin
              head_q[qid] = nx;
            end else begin
              relink(prev, nx);
            end
            if (cur == tail_q[qid]) tail_q[qid] = prev;
            relink(cur, NIL);
          end else begin
            r.status = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
    expected_rsp.push_back(r);
  endfunction

  function void check_response(entry_t out_entry, status_t status);
    rsp_fields_t exp_rsp;
    if (expected_rsp.size() == 0) begin
      $error("Response transaction with no request outstanding: out_entry %0d, status %0d",
             out_entry, status);
      mismatches++;
      return;
    end
    exp_rsp = expected_rsp.pop_front();
    if (out_entry !== exp_rsp.out_entry) begin
      $error("out_entry: expected %0d, actual %0d", exp_rsp.out_entry, out_entry);
      mismatches++;
    end
    if (status !== exp_rsp.status) begin
      $error("status: expected %0d, actual %0d", exp_rsp.status, status);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int    RANDOM_REQS = 1125;
  localparam int    IDLE_PCT    = 23;
  localparam int    HOLD_AT     = 250;
  localparam int    HOLD_CYCLES = 400;
  localparam int    STALL_LIMIT = 3000;
  localparam int    DRAIN_CYCLES = 300;

  logic clk;
  logic rst;

  lqm_req_if req_ch ();
  lqm_rsp_if rsp_ch ();

  linked_queue_manager i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_table_scoreboard sb = new();

  bit sender_busy_idle;
  int rsp_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(mode_t mode, queue_t qid, entry_t eid);
    while (sender_busy_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.queue_id <= qid;
    req_ch.entry_id <= eid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(mode, qid, eid);
    @(negedge clk);
  endtask

  task automatic pick_request(output mode_t mode, output queue_t qid, output entry_t eid);
    int     r;
    bit     held[NUM_ENTRIES];
    entry_t candidates[$];
    r = $urandom_range(0, 99);
    qid = $urandom_range(0, 1) ? queue_t'($urandom_range(0, 2)) : queue_t'($urandom);
    eid = entry_t'($urandom);
    if (r < 3) begin
      mode = MODE_UNUSED;
    end else if (r < 45) begin
      mode = MODE_APPEND;
      if ($urandom_range(0, 99) < 95) begin
        sb.occupancy(held);
        foreach (held[i]) if (!held[i]) candidates.push_back(entry_t'(i));
        if (candidates.size() != 0) eid = candidates[$urandom_range(0, candidates.size() - 1)];
      end
    end else if (r < 72) begin
      mode = MODE_POP;
    end else begin
      mode = MODE_REMOVE;
      if ($urandom_range(0, 99) < 85) begin
        sb.collect(qid, candidates);
        if (candidates.size() != 0) eid = candidates[$urandom_range(0, candidates.size() - 1)];
      end
    end
  endtask

  initial begin
    mode_t  mode;
    queue_t qid;
    entry_t eid;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_APPEND;
    req_ch.queue_id = '0;
    req_ch.entry_id = '0;
    sender_busy_idle = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(MODE_POP, 3'd0, 6'd63);
    send(MODE_REMOVE, 3'd7, 6'd0);
    send(MODE_APPEND, 3'd0, 6'd0);
    send(MODE_APPEND, 3'd0, 6'd63);
    send(MODE_APPEND, 3'd0, 6'd21);
    send(MODE_REMOVE, 3'd0, 6'd42);
    send(MODE_REMOVE, 3'd0, 6'd63);
    send(MODE_REMOVE, 3'd0, 6'd21);
    send(MODE_APPEND, 3'd0, 6'd42);
    send(MODE_POP, 3'd0, 6'd0);
    send(MODE_POP, 3'd0, 6'd0);
    send(MODE_POP, 3'd0, 6'd0);
    send(MODE_UNUSED, 3'd5, 6'd33);
    send(MODE_APPEND, 3'd2, 6'd63);
    send(MODE_POP, 3'd2, 6'd0);
    send(MODE_APPEND, 3'd3, 6'd5);
    send(MODE_APPEND, 3'd3, 6'd6);
    send(MODE_REMOVE, 3'd3, 6'd5);
    send(MODE_APPEND, 3'd7, 6'd42);
    send(MODE_APPEND, 3'd7, 6'd42);
    send(MODE_REMOVE, 3'd7, 6'd7);
    send(MODE_REMOVE, 3'd7, 6'd42);
    send(MODE_APPEND, 3'd7, 6'd1);
    send(MODE_POP, 3'd7, 6'd0);
    send(MODE_POP, 3'd3, 6'd0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      sender_busy_idle = !(i >= 400 && i < 600);
      pick_request(mode, qid, eid);
      send(mode, qid, eid);
    end
    req_ch.valid <= 1'b0;

    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    bit held_off;
    int hold_left;
    held_off = 1'b0;
    hold_left = 0;
    rsp_count = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && rsp_count >= HOLD_AT) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_count >= 700 && rsp_count < 900) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.out_entry, rsp_ch.status);
        rsp_count++;
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
      if (stalled >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lqm_pkg.sv
rtl/core/lqm_ifs.sv
rtl/core/lqm_ram.sv
rtl/core/lqm_dpath.sv
rtl/core/lqm_ctrl.sv
rtl/core/linked_queue_manager.sv
tb/sv/tb_top.sv
